// ===== hw/rtl/tlpts_pkg.sv =====
// Package: shared types, constants and event codes for the thread scheduler.
package tlpts_pkg;

    localparam int THREADS_DEF   = 16;
    localparam logic [15:0] QUANTUM_RESET = 16'd20;
    localparam logic PRIO_HIGH = 1'b1;
    localparam logic PRIO_LOW  = 1'b0;

    typedef enum logic [2:0] {
        FN_CREATE = 3'd0,
        FN_TICK   = 3'd1,
        FN_BLOCK  = 3'd2,
        FN_PACKET = 3'd3,
        FN_EXIT   = 3'd4,
        FN_SETPRI = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOSLOT  = 3'd1,
        ST_DROPPED = 3'd2,
        ST_ALLDONE = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        Q_LOW  = 2'd0,
        Q_HIGH = 2'd1,
        Q_WAIT = 2'd2
    } queue_t;

    typedef struct packed {
        logic [2:0] func;
        logic       priority_req;
    } in_item_t;

    typedef struct packed {
        logic [3:0] running_thread;
        logic       running_idle;
        logic       running_priority;
        logic [3:0] new_thread;
        logic       switched;
        logic [2:0] status;
    } out_item_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,  // event decision, push, pop address
        S_POP,     // queue read data back
        S_PUSH2,   // second push (woken thread)
        S_DISP,    // dispatch pop address
        S_FINISH,  // dispatch data back
        S_DONE     // emit result
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic decide;
        logic wake_push;
        logic disp_read;
        logic disp_take;
        logic emit;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic need_wake;  // packet pops wait head
        logic need_disp;  // event dispatches
    } stat_t;

endpackage

// ===== hw/rtl/tlpts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tlpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/tlpts_ctrl.sv =====
// Controller: sequences one event through decide, wake and dispatch steps.
module tlpts_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  tlpts_pkg::stat_t stat,
    output tlpts_pkg::cmd_t  cmd,
    output logic            busy
);
    import tlpts_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (start) state_next = S_DECIDE;
            S_DECIDE: state_next = stat.need_wake ? S_POP
                                 : (stat.need_disp ? S_DISP : S_DONE);
            S_POP:    state_next = S_PUSH2;
            S_PUSH2:  state_next = stat.need_disp ? S_DISP : S_DONE;
            S_DISP:   state_next = S_FINISH;
            S_FINISH: state_next = S_DONE;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:   ;
            S_DECIDE: cmd.decide = 1'b1;
            S_POP:    ;
            S_PUSH2:  cmd.wake_push = 1'b1;
            S_DISP:   cmd.disp_read = 1'b1;
            S_FINISH: cmd.disp_take = 1'b1;
            S_DONE:   cmd.emit = 1'b1;
            default:  ;
        endcase
    end

`ifndef SYNTH
    a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> !cmd.emit)
        else $error("emit lasted more than one cycle");
    a_take_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.disp_read |=> cmd.disp_take)
        else $error("dispatch read not followed by take");
    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> cmd.decide)
        else $error("accepted item did not reach decide");
`endif
endmodule

// ===== hw/rtl/tlpts_dp.sv =====
// Datapath: queue memories, pointers, slot tables, runner state and result.
module tlpts_dp #(
    parameter int THREADS = tlpts_pkg::THREADS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  tlpts_pkg::in_item_t in_item,
    input  logic [15:0]         quantum,
    input  tlpts_pkg::cmd_t     cmd,
    output tlpts_pkg::stat_t    stat,
    output tlpts_pkg::out_item_t result,
    output logic                result_valid
);
    import tlpts_pkg::*;

    localparam int SW = $clog2(THREADS);
    localparam int CW = $clog2(THREADS + 1);

    // Queue pointers.
    logic [SW-1:0] head_reg [3];
    logic [CW-1:0] cnt_reg  [3];

    logic [THREADS-1:0] used_reg, prio_reg;
    logic [SW-1:0]      cur_reg;
    logic               idle_reg;
    logic [15:0]        ticks_reg;

    in_item_t      item_reg;
    logic [SW-1:0] prev_cur_reg;
    logic          prev_idle_reg;
    logic [SW-1:0] newt_reg;
    status_t       status_reg;
    logic          need_disp_reg;
    queue_t        dq_reg;

    // RAM ports.
    logic          we   [3];
    logic [SW-1:0] wa   [3];
    logic [SW-1:0] wd   [3];
    logic [SW-1:0] ra   [3];
    logic [SW-1:0] rd   [3];

    for (genvar q = 0; q < 3; q++)
    begin : g_q
        tlpts_ram #(.WIDTH(SW), .DEPTH(THREADS)) u_ram (
            .clk(clk), .we(we[q]), .waddr(wa[q]), .wdata(wd[q]),
            .raddr(ra[q]), .rdata(rd[q])
        );
    end

    // First free slot, linear priority encoder.
    logic [SW-1:0] free_idx;
    logic          free_any;
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = THREADS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = SW'(i);
                free_any = 1'b1;
            end
        end
    end

    function automatic logic [SW-1:0] wrap_add(input logic [SW-1:0] h,
                                               input logic [CW-1:0] c);
        logic [CW:0] s;
        begin
            s = {1'b0, {(CW - SW){1'b0}}, h} + {1'b0, c};
            if (s >= (CW + 1)'(THREADS))
            begin
                s = s - (CW + 1)'(THREADS);
            end
            return s[SW-1:0];
        end
    endfunction

    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] h);
        begin
            return (h == SW'(THREADS - 1)) ? '0 : h + 1'b1;
        end
    endfunction

    // Decide-step combinational plan.
    logic          p1_en, p2_en;
    queue_t        p1_q, p2_q;
    logic [SW-1:0] p1_v, p2_v;
    logic          d_wake, d_disp, d_idle_clr_used;
    status_t       d_status;
    logic [SW-1:0] d_newt;
    logic          d_set_used, d_set_prio, d_prio_val;
    logic [SW-1:0] d_prio_idx;
    logic          d_tick_dec, d_tick_reload;
    logic          cur_low;

    always_comb
    begin
        p1_en = 1'b0; p2_en = 1'b0;
        p1_q = Q_LOW; p2_q = Q_LOW;
        p1_v = '0; p2_v = '0;
        d_wake = 1'b0; d_disp = 1'b0; d_idle_clr_used = 1'b0;
        d_status = ST_OK; d_newt = '0;
        d_set_used = 1'b0; d_set_prio = 1'b0; d_prio_val = 1'b0; d_prio_idx = cur_reg;
        d_tick_dec = 1'b0; d_tick_reload = 1'b0;
        cur_low = (prio_reg[cur_reg] == PRIO_LOW);
        case (item_reg.func)
            FN_CREATE:
            begin
                if (!free_any)
                begin
                    d_status = ST_NOSLOT;
                end
                else
                begin
                    d_set_used = 1'b1;
                    d_set_prio = 1'b1;
                    d_prio_idx = free_idx;
                    d_prio_val = item_reg.priority_req;
                    d_newt = free_idx;
                    p1_en = 1'b1;
                    p1_q = item_reg.priority_req ? Q_HIGH : Q_LOW;
                    p1_v = free_idx;
                    if (idle_reg)
                    begin
                        d_disp = 1'b1;
                    end
                    else if (item_reg.priority_req == PRIO_HIGH && cur_low)
                    begin
                        p2_en = 1'b1; p2_q = Q_LOW; p2_v = cur_reg;
                        d_disp = 1'b1;
                    end
                end
            end
            FN_TICK:
            begin
                if (!idle_reg && cur_low)
                begin
                    if (ticks_reg > 16'd1)
                    begin
                        d_tick_dec = 1'b1;
                    end
                    else if (cnt_reg[Q_HIGH] != '0 || cnt_reg[Q_LOW] != '0)
                    begin
                        p1_en = 1'b1; p1_q = Q_LOW; p1_v = cur_reg;
                        d_disp = 1'b1;
                    end
                    else
                    begin
                        d_tick_reload = 1'b1;
                    end
                end
            end
            FN_BLOCK:
            begin
                if (idle_reg || cur_reg == '0)
                begin
                    d_status = ST_IGNORED;
                end
                else
                begin
                    p1_en = 1'b1; p1_q = Q_WAIT; p1_v = cur_reg;
                    d_disp = 1'b1;
                end
            end
            FN_PACKET:
            begin
                if (cnt_reg[Q_WAIT] == '0)
                begin
                    d_status = ST_DROPPED;
                end
                else
                begin
                    d_wake = 1'b1;
                    d_disp = idle_reg;
                end
            end
            FN_EXIT:
            begin
                if (idle_reg)
                begin
                    d_status = ST_IGNORED;
                end
                else
                begin
                    d_idle_clr_used = 1'b1;
                    d_disp = 1'b1;
                end
            end
            FN_SETPRI:
            begin
                if (idle_reg)
                begin
                    d_status = ST_IGNORED;
                end
                else
                begin
                    d_set_prio = 1'b1;
                    d_prio_val = item_reg.priority_req;
                end
            end
            default: d_status = ST_IGNORED;
        endcase
    end

    // Dispatch queue choice uses counts after the decide-step pushes.
    queue_t dq_pick;
    logic   dq_none;
    always_comb
    begin
        dq_none = 1'b0;
        if (cnt_reg[Q_HIGH] != '0)
        begin
            dq_pick = Q_HIGH;
        end
        else if (cnt_reg[Q_LOW] != '0)
        begin
            dq_pick = Q_LOW;
        end
        else
        begin
            dq_pick = Q_LOW;
            dq_none = 1'b1;
        end
    end

    // Wake: woken slot from the wait queue read data.
    logic [SW-1:0] woken;
    assign woken = rd[Q_WAIT];

    // RAM port drive. Decide pushes up to two entries, always to distinct queues;
    // p2 is used only for create-high preemption (runner to low), while p1
    // targets high, so ports never collide.
    always_comb
    begin
        for (int q = 0; q < 3; q++)
        begin
            we[q] = 1'b0;
            wa[q] = '0;
            wd[q] = '0;
            ra[q] = head_reg[q];
        end
        if (cmd.decide)
        begin
            if (p1_en && cnt_reg[p1_q] < CW'(THREADS))
            begin
                we[p1_q] = 1'b1;
                wa[p1_q] = wrap_add(head_reg[p1_q], cnt_reg[p1_q]);
                wd[p1_q] = p1_v;
            end
            if (p2_en && cnt_reg[p2_q] < CW'(THREADS))
            begin
                we[p2_q] = 1'b1;
                wa[p2_q] = wrap_add(head_reg[p2_q], cnt_reg[p2_q]);
                wd[p2_q] = p2_v;
            end
        end
        else if (cmd.wake_push)
        begin
            if (prio_reg[woken] == PRIO_HIGH)
            begin
                if (cnt_reg[Q_HIGH] < CW'(THREADS))
                begin
                    we[Q_HIGH] = 1'b1;
                    wa[Q_HIGH] = wrap_add(head_reg[Q_HIGH], cnt_reg[Q_HIGH]);
                    wd[Q_HIGH] = woken;
                end
            end
            else if (cnt_reg[Q_LOW] < CW'(THREADS))
            begin
                we[Q_LOW] = 1'b1;
                wa[Q_LOW] = wrap_add(head_reg[Q_LOW], cnt_reg[Q_LOW]);
                wd[Q_LOW] = woken;
            end
        end
    end

    assign stat.need_wake = d_wake;
    assign stat.need_disp = cmd.decide ? d_disp : need_disp_reg;

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= in_item;
            prev_cur_reg <= cur_reg;
            prev_idle_reg <= idle_reg;
        end
        if (cmd.decide)
        begin
            status_reg <= d_status;
            newt_reg <= d_newt;
        end
        if (cmd.disp_read)
        begin
            dq_reg <= dq_pick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < 3; q++)
            begin
                head_reg[q] <= '0;
                cnt_reg[q] <= '0;
            end
            used_reg <= {{(THREADS - 1){1'b0}}, 1'b1};
            prio_reg <= '0;
            cur_reg <= '0;
            idle_reg <= 1'b0;
            ticks_reg <= QUANTUM_RESET;
            need_disp_reg <= 1'b0;
            result_valid <= 1'b0;
            result <= '0;
        end
        else
        begin
            result_valid <= cmd.emit;
            if (cmd.decide)
            begin
                need_disp_reg <= d_disp;
                for (int q = 0; q < 3; q++)
                begin
                    if (we[q])
                    begin
                        cnt_reg[q] <= cnt_reg[q] + 1'b1;
                    end
                end
                if (d_set_used) used_reg[free_idx] <= 1'b1;
                if (d_idle_clr_used) used_reg[cur_reg] <= 1'b0;
                if (d_set_prio) prio_reg[d_prio_idx] <= d_prio_val;
                if (d_tick_dec) ticks_reg <= ticks_reg - 16'd1;
                if (d_tick_reload) ticks_reg <= quantum;
            end
            if (cmd.wake_push)
            begin
                for (int q = 0; q < 2; q++)
                begin
                    if (we[q])
                    begin
                        cnt_reg[q] <= cnt_reg[q] + 1'b1;
                    end
                end
                // wait head leaves once its read data has been used
                head_reg[Q_WAIT] <= wrap_inc(head_reg[Q_WAIT]);
                cnt_reg[Q_WAIT] <= cnt_reg[Q_WAIT] - 1'b1;
            end
            if (cmd.disp_read)
            begin
                ticks_reg <= quantum;
                if (dq_none)
                begin
                    cur_reg <= '0;
                    idle_reg <= 1'b1;
                    need_disp_reg <= 1'b0;
                end
                else
                begin
                    idle_reg <= 1'b0;
                    head_reg[dq_pick] <= wrap_inc(head_reg[dq_pick]);
                    cnt_reg[dq_pick] <= cnt_reg[dq_pick] - 1'b1;
                end
            end
            if (cmd.disp_take && need_disp_reg)
            begin
                cur_reg <= rd[dq_reg];
            end
            if (cmd.emit)
            begin
                result.running_thread <= idle_reg ? 4'd0 : 4'(cur_reg);
                result.running_idle <= idle_reg;
                result.running_priority <= idle_reg ? 1'b0 : prio_reg[cur_reg];
                result.new_thread <= 4'(newt_reg);
                result.switched <= (prev_idle_reg != idle_reg) ||
                                   (!idle_reg && prev_cur_reg != cur_reg);
                result.status <= (item_reg.func == FN_EXIT && status_reg == ST_OK
                                  && idle_reg && cnt_reg[Q_WAIT] == '0)
                                 ? ST_ALLDONE : status_reg;
                need_disp_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[Q_HIGH] <= CW'(THREADS) && cnt_reg[Q_LOW] <= CW'(THREADS)
        && cnt_reg[Q_WAIT] <= CW'(THREADS))
        else $error("queue count exceeds depth");
    a_slot0_used: assert property (@(posedge clk) disable iff (!rst_n)
        (!idle_reg && cur_reg == '0) |-> used_reg[0] || busy)
        else $error("runner slot 0 not in use");
    a_wake_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        d_wake && cmd.decide |-> cnt_reg[Q_WAIT] != '0)
        else $error("wake on empty wait queue");
`endif
endmodule

// ===== hw/rtl/two_level_priority_thread_scheduler.sv =====
// Top level: two-level priority thread scheduler with APB quantum register.
// Steps: decide, then optional wake read and wake push, then optional dispatch
// read and take, then emit; the result strobe is registered after emit. A new
// event is accepted only while busy is low; busy holds until the strobe cycle.
// Result is shown for one cycle under done; the receiver cannot stall. Reset
// (async, rst_n low): queues empty, slot 0 runs at low priority, quantum 20,
// ticks reloaded; queue RAMs hold no reset values.
module two_level_priority_thread_scheduler #(
    parameter int THREADS = tlpts_pkg::THREADS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel
    input  logic                 start,
    input  tlpts_pkg::in_item_t  in_item,
    output logic                 busy,
    // result channel
    output logic                 done,
    output tlpts_pkg::out_item_t result,
    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import tlpts_pkg::*;

    localparam logic [1:0] ADDR_QUANTUM = 2'd0;

    logic [15:0] quantum_reg;
    cmd_t        cmd;
    stat_t       stat;

    assign pready = 1'b1;
    // Single register at byte address 0.
    assign prdata = (paddr == ADDR_QUANTUM) ? {16'd0, quantum_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else if (psel && penable && pwrite && paddr == ADDR_QUANTUM)
        begin
            quantum_reg <= pwdata[15:0];
        end
    end

    tlpts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .stat(stat),
        .cmd(cmd), .busy(busy)
    );

    tlpts_dp #(.THREADS(THREADS)) u_dp (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .in_item(in_item), .quantum(quantum_reg), .cmd(cmd), .stat(stat),
        .result(result), .result_valid(done)
    );

`ifndef SYNTH
    a_done_not_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");
    a_done_follows_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> done)
        else $error("emit did not raise done");
    a_no_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !$past(busy)) |-> !done)
        else $error("spurious result strobe");
`endif
endmodule
